@@ design/mlpf_pkg.sv @@
// Shared constants, types and helpers for the memo line position finder.
`timescale 1ns / 1ps
`default_nettype none

package mlpf_pkg;

  // Text store geometry
  localparam int MAX_TEXT = 4096;
  localparam int ADDR_W   = $clog2(MAX_TEXT);
  localparam int LEN_W    = $clog2(MAX_TEXT + 2);

  // Layout arithmetic widths
  localparam int LINE_W = 13;
  localparam int COL_W  = 11;

  // Line width fallback
  localparam logic [7:0] WIDTH_DEFAULT = 8'd79;
  localparam logic [7:0] WIDTH_MIN     = 8'd4;

  // Characters of interest
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_TAB_WIDTH  = 2'd1,
    CFG_WORD_WRAP  = 2'd2
  } cfg_index_t;

  // Request kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Scan sequencer states
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_EVAL,
    SC_PEEK
  } scan_state_t;

  // Effective layout settings handed to the scanner
  typedef struct packed {
    logic [7:0] width;
    logic [7:0] tab_m1;
    logic       wrap;
  } scan_cfg_t;

endpackage

`default_nettype wire

@@ design/memo_line_position_finder.sv @@
// Top level of the memo line position finder: loader, settings and scanner.
//
// Usage: a request is taken at a clock edge where start is high and busy is
// low. With action low the request loads text_byte into the text store in
// that cycle; busy stays low, so loads stream one per cycle. last_byte
// closes the text, and the next load starts a new one. Bytes beyond 4096
// are dropped. With action high the request asks where line target_line
// starts. busy rises the next cycle while the scanner walks the text; the
// scanner steps over the text byte by byte and looks one byte ahead on
// each word wrap, all through the single read port of the text store.
// busy is low again in the cycle where done pulses for one cycle with
// line_start. A query on empty text answers in the cycle after the request.
// The receiver cannot stall; line_start is valid only while done is high.
// Settings are written through cfg_write/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it. Reset
// empties the text and loads width 79, tab 1 and word wrap on; the text
// store itself is not cleared, so there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module memo_line_position_finder (
  input  wire        clk,
  input  wire        rst,
  input  wire        start,
  output logic       busy,
  input  wire        action,
  input  wire [7:0]  text_byte,
  input  wire        last_byte,
  input  wire [12:0] target_line,
  output logic       done,
  output logic [12:0] line_start,
  input  wire        cfg_write,
  input  wire [1:0]  cfg_index,
  input  wire [7:0]  cfg_data
);
  import mlpf_pkg::*;

  logic [7:0]       line_width;
  logic [7:0]       tab_width;
  logic             word_wrap;
  logic [LEN_W-1:0] text_length;
  logic             text_closed;

  logic             accept;
  logic             load;
  logic             query;
  logic [LEN_W-1:0] load_base;
  logic             load_fits;
  logic [7:0]       width_eff;
  logic [7:0]       tab_eff;
  scan_cfg_t        scan_cfg;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic             scan_busy;

  assign accept = start && !busy;
  assign load   = accept && (action == ACT_LOAD);
  assign query  = accept && (action == ACT_QUERY);
  assign busy   = scan_busy;

  // Settings register file
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= WIDTH_DEFAULT;
      tab_width  <= 8'd1;
      word_wrap  <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH: line_width <= cfg_data;
        CFG_TAB_WIDTH:  tab_width  <= cfg_data;
        CFG_WORD_WRAP:  word_wrap  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp width and tab to their working ranges
  always_comb begin
    width_eff = (line_width <= WIDTH_MIN) ? WIDTH_DEFAULT : line_width;
    tab_eff   = (tab_width == 8'd0) ? 8'd1 : tab_width;
    if (tab_eff >= width_eff) begin
      tab_eff = width_eff - 8'd1;
    end
    scan_cfg.width  = width_eff;
    scan_cfg.tab_m1 = tab_eff - 8'd1;
    scan_cfg.wrap   = word_wrap;
  end

  // Restart the text on the first load after it was closed
  assign load_base = text_closed ? '0 : text_length;
  assign load_fits = (load_base < LEN_W'(MAX_TEXT));

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length <= '0;
      text_closed <= 1'b1;
    end else if (load) begin
      text_closed <= last_byte;
      text_length <= load_fits ? load_base + LEN_W'(1) : load_base;
    end
  end

  mlpf_text_ram u_ram (
    .clk   (clk),
    .we    (load && load_fits),
    .waddr (load_base[ADDR_W-1:0]),
    .wdata (text_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mlpf_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .go       (query),
    .target   (target_line),
    .cfg      (scan_cfg),
    .text_len (text_length),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .busy     (scan_busy),
    .done     (done),
    .result   (line_start)
  );

`ifndef SYNTH
  // Answer always lies within the text or just past it
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (line_start >= 13'd1) &&
             ({1'b0, line_start} <= {1'b0, text_length} + 14'd1))
    else $error("line_start out of range");

  // A query either starts a walk or answers at once
  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_QUERY) |=> (busy || done))
    else $error("query neither started nor answered");

  // A load never produces an answer
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_LOAD) |=> !done)
    else $error("answer after a load");

  // Stored length never passes the store size
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    text_length <= LEN_W'(MAX_TEXT))
    else $error("text length past store size");
`endif

endmodule

`default_nettype wire

@@ design/mlpf_text_ram.sv @@
// Single write, single registered read text byte store.
`timescale 1ns / 1ps
`default_nettype none

module mlpf_text_ram (
  input  wire                      clk,
  input  wire                      we,
  input  wire [mlpf_pkg::ADDR_W-1:0] waddr,
  input  wire [7:0]                wdata,
  input  wire [mlpf_pkg::ADDR_W-1:0] raddr,
  output logic [7:0]               rdata
);
  import mlpf_pkg::*;

  logic [7:0] mem [MAX_TEXT];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/mlpf_scan.sv @@
// Line start scanner: walks the stored text one byte per step.
`timescale 1ns / 1ps
`default_nettype none

module mlpf_scan (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        go,
  input  wire [12:0]                 target,
  input  mlpf_pkg::scan_cfg_t        cfg,
  input  wire [mlpf_pkg::LEN_W-1:0]  text_len,
  output logic [mlpf_pkg::ADDR_W-1:0] rd_addr,
  input  wire [7:0]                  rd_data,
  output logic                       busy,
  output logic                       done,
  output logic [12:0]                result
);
  import mlpf_pkg::*;

  scan_state_t state, state_next;

  logic [LEN_W-1:0]         pos, pos_next;
  logic signed [COL_W-1:0]  col, col_next;
  logic [LINE_W-1:0]        line, line_next;
  logic [LEN_W-1:0]         space_at, space_at_next;
  logic                     have_space, have_space_next;
  logic [LINE_W-1:0]        want, want_next;
  logic                     done_next;
  logic [12:0]              result_next;

  // Step datapath
  logic                     is_space;
  logic [LEN_W-1:0]         sa1;
  logic                     hs1;
  logic                     brk;
  logic                     wrap_try;
  logic [LEN_W-1:0]         pos_inc;
  logic [LINE_W-1:0]        line1;
  logic signed [COL_W-1:0]  col1;
  logic signed [COL_W-1:0]  colt;
  logic signed [COL_W-1:0]  width_col;
  logic                     hit;
  logic [LEN_W-1:0]         resume;
  logic [LEN_W-1:0]         resume_inc;

  assign busy = (state != SC_IDLE);

  // Evaluate the byte just read against the current line
  always_comb begin
    width_col = $signed({{(COL_W-8){1'b0}}, cfg.width});
    is_space  = (rd_data == CH_SPACE);
    sa1       = is_space ? pos : space_at;
    hs1       = have_space | is_space;
    pos_inc   = pos + LEN_W'(1);
    brk       = (col >= width_col) || (rd_data == CH_LF);
    wrap_try  = cfg.wrap && hs1 && (pos_inc < text_len) && (rd_data != CH_LF);
    line1     = line + LINE_W'(brk);
    col1      = brk ? '0 : col;
    colt      = col1;
    if (rd_data == CH_TAB) begin
      colt = col1 + $signed({{(COL_W-8){1'b0}}, cfg.tab_m1});
    end
    if (rd_data == CH_CR) begin
      colt = col1 - COL_W'(1);
    end
    hit        = (line1 >= want) && (colt >= COL_W'(1));
    // After a wrap the new line begins just past a space
    resume     = (rd_data == CH_SPACE) ? pos_inc : space_at;
    resume_inc = resume + LEN_W'(1);
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    pos_next        = pos;
    col_next        = col;
    line_next       = line;
    space_at_next   = space_at;
    have_space_next = have_space;
    want_next       = want;
    done_next       = 1'b0;
    result_next     = result;
    rd_addr         = pos[ADDR_W-1:0];
    unique case (state)
      SC_IDLE: begin
        if (go) begin
          pos_next        = '0;
          col_next        = COL_W'(1);
          line_next       = LINE_W'(1);
          have_space_next = 1'b0;
          space_at_next   = '0;
          want_next       = (target <= 13'd1) ? LINE_W'(1) : target;
          rd_addr         = '0;
          if (text_len == '0) begin
            done_next   = 1'b1;
            result_next = 13'd1;
          end else begin
            state_next = SC_EVAL;
          end
        end
      end
      SC_EVAL: begin
        space_at_next = sa1;
        if (brk && wrap_try) begin
          // Look one byte ahead before backing up to the space
          rd_addr    = pos_inc[ADDR_W-1:0];
          state_next = SC_PEEK;
        end else begin
          have_space_next = brk ? 1'b0 : hs1;
          line_next       = line1;
          if (hit) begin
            done_next   = 1'b1;
            result_next = pos_inc[12:0];
            state_next  = SC_IDLE;
          end else begin
            pos_next = pos_inc;
            col_next = colt + COL_W'(1);
            rd_addr  = pos_inc[ADDR_W-1:0];
            if (pos_inc >= text_len) begin
              done_next   = 1'b1;
              result_next = 13'(pos_inc + LEN_W'(1));
              state_next  = SC_IDLE;
            end
          end
        end
      end
      SC_PEEK: begin
        line_next       = line + LINE_W'(1);
        have_space_next = 1'b0;
        pos_next        = resume_inc;
        col_next        = COL_W'(1);
        rd_addr         = resume_inc[ADDR_W-1:0];
        if (resume_inc >= text_len) begin
          done_next   = 1'b1;
          result_next = 13'(resume_inc + LEN_W'(1));
          state_next  = SC_IDLE;
        end else begin
          state_next = SC_EVAL;
        end
      end
      default: begin
        state_next = SC_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    pos        <= pos_next;
    col        <= col_next;
    line       <= line_next;
    space_at   <= space_at_next;
    have_space <= have_space_next;
    want       <= want_next;
    result     <= result_next;
  end

endmodule

`default_nettype wire
